// File: hw/rtl/srh_pkg.sv
// ---------------------------------------------------------------------------
// Substring rolling hash package
// Widths, the Mersenne modulus and the item and status codes.
// ---------------------------------------------------------------------------
package srh_pkg;

   localparam int MAX_LENGTH = 1024;
   localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
   localparam int HASH_W     = 61;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;

   localparam logic [HASH_W-1:0] HASH_MOD   = {HASH_W{1'b1}};
   localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(131);

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

// File: hw/rtl/srh_mulmod.sv
// ---------------------------------------------------------------------------
// Modular multiplier, modulus 2^61-1
// Multi-cycle product of two reduced operands from four 32-by-32 partial
// products, accumulated and folded; done pulses once the folded product is registered.
// ---------------------------------------------------------------------------
module srh_mulmod
   import srh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] op_a,
   input  logic [HASH_W-1:0] op_b,
   output logic              done,
   output logic [HASH_W-1:0] product
);

   localparam int HALF_W = 32;
   localparam int PROD_W = 2 * HALF_W;
   localparam int ACC_W  = 2 * HASH_W;

   localparam logic [2:0] CNT_LAST_PP = 3'd3;
   localparam logic [2:0] CNT_ACC_END = 3'd4;
   localparam logic [2:0] CNT_SUM     = 3'd5;
   localparam logic [2:0] CNT_FOLD    = 3'd6;

   localparam logic [1:0] PAIR_LL = 2'd0;
   localparam logic [1:0] PAIR_LH = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_HH = 2'd3;

   logic              busy_ff;
   logic [2:0]        cnt_ff;
   logic              done_ff;
   logic [HASH_W-1:0] a_ff;
   logic [HASH_W-1:0] b_ff;
   logic [PROD_W-1:0] pp_ff;
   logic [1:0]        pair_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [HASH_W:0]   sum_ff;
   logic [HASH_W-1:0] product_ff;

   logic [HALF_W-1:0] mul_x;
   logic [HALF_W-1:0] mul_y;
   logic [ACC_W-1:0]  pp_shifted;
   logic [HASH_W:0]   fold_sum;

   always_comb begin
      case (cnt_ff[1:0])
         PAIR_LL: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[HALF_W-1:0];
         end
         PAIR_LH: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = HALF_W'(b_ff[HASH_W-1:HALF_W]);
         end
         PAIR_HL: begin
            mul_x = HALF_W'(a_ff[HASH_W-1:HALF_W]);
            mul_y = b_ff[HALF_W-1:0];
         end
         PAIR_HH: begin
            mul_x = HALF_W'(a_ff[HASH_W-1:HALF_W]);
            mul_y = HALF_W'(b_ff[HASH_W-1:HALF_W]);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   always_comb begin
      case (pair_ff)
         PAIR_LL:          pp_shifted = ACC_W'(pp_ff);
         PAIR_LH, PAIR_HL: pp_shifted = ACC_W'({pp_ff, {HALF_W{1'b0}}});
         PAIR_HH:          pp_shifted = {pp_ff[ACC_W-PROD_W-1:0], {PROD_W{1'b0}}};
         default:          pp_shifted = '0;
      endcase
   end

   assign fold_sum = {1'b0, sum_ff[HASH_W-1:0]} + (HASH_W + 1)'(sum_ff[HASH_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= op_a;
            b_ff    <= op_b;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff <= CNT_LAST_PP) begin
               pp_ff   <= PROD_W'(mul_x) * PROD_W'(mul_y);
               pair_ff <= cnt_ff[1:0];
            end
            if (cnt_ff != 3'd0 && cnt_ff <= CNT_ACC_END) begin
               acc_ff <= acc_ff + pp_shifted;
            end
            if (cnt_ff == CNT_SUM) begin
               sum_ff <= {1'b0, acc_ff[ACC_W-1:HASH_W]} + {1'b0, acc_ff[HASH_W-1:0]};
            end
            if (cnt_ff == CNT_FOLD) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               if (fold_sum >= {1'b0, HASH_MOD}) begin
                  product_ff <= HASH_W'(fold_sum - {1'b0, HASH_MOD});
               end else begin
                  product_ff <= fold_sum[HASH_W-1:0];
               end
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

// File: hw/rtl/substring_rolling_hash_table.sv
// ---------------------------------------------------------------------------
// Substring rolling hash table
// Prefix hashes and base powers modulo 2^61-1 held in two memories; append
// items extend them, query items return the hash of a stored substring.
// ---------------------------------------------------------------------------
//  Channel  Direction  Ports                      Moves
//  req      in         req_valid / req_ready      one append or query item
//  rsp      out        rsp_valid / rsp_ready      one result per item
//  csr      in         csr_wr_en / csr_wr_data    hash base, written at once
//
//  A new item is accepted only in ST_IDLE. A rejected item (store full or
//  bad range) goes straight to ST_DONE; appends and queries wait on the
//  four-step 32-by-32 multiply in srh_mulmod, queries also on the memory read.
//  Reset is synchronous and needs no clearing pass: entry zero of each table
//  is supplied by logic. A stalled result waits in the output register while
//  the next item is accepted and worked on.
// ---------------------------------------------------------------------------
module substring_rolling_hash_table
   import srh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [BYTE_W-1:0]   req_byte_value,
   input  logic                req_restart,
   input  logic [LEN_W-1:0]    req_range_start,
   input  logic [LEN_W-1:0]    req_range_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [HASH_W-1:0]   rsp_hash_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LEN_W-1:0]    rsp_stored_length,
   input  logic                csr_wr_en,
   input  logic [HASH_W-1:0]   csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_WAIT,
      ST_FINISH,
      ST_DONE
   } state_type;

   state_type           state_ff;
   logic [HASH_W-1:0]   hash_base_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [HASH_W-1:0]   last_hash_ff;
   logic [HASH_W-1:0]   last_pow_ff;

   logic                kind_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic [LEN_W-1:0]    lo_ff;
   logic [LEN_W-1:0]    hi_ff;
   logic [LEN_W-1:0]    diff_ff;
   logic [LEN_W-1:0]    n_ff;
   logic [HASH_W-1:0]   h_op_ff;
   logic [HASH_W-1:0]   p_op_ff;
   logic [HASH_W-1:0]   base_ff;

   logic [HASH_W-1:0]   res_hash_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [LEN_W-1:0]    res_len_ff;

   logic                rsp_valid_ff;
   logic [HASH_W-1:0]   rsp_hash_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]    rsp_len_ff;

   logic [HASH_W-1:0]   prefix_mem [0:MAX_LENGTH];
   logic [HASH_W-1:0]   power_mem  [0:MAX_LENGTH];
   logic [HASH_W-1:0]   rd_lo_ff;
   logic [HASH_W-1:0]   rd_hi_ff;
   logic [HASH_W-1:0]   rd_pow_ff;

   logic [LEN_W-1:0]    n_eff;
   logic [HASH_W-1:0]   base_eff;
   logic                range_bad;
   logic [HASH_W-1:0]   lo_hash;
   logic [HASH_W-1:0]   hi_hash;
   logic [HASH_W-1:0]   diff_pow;
   logic                start_a;
   logic                start_b;
   logic [HASH_W-1:0]   op_a1;
   logic [HASH_W-1:0]   op_a2;
   logic                done_a;
   logic                done_b;
   logic [HASH_W-1:0]   prod_a;
   logic [HASH_W-1:0]   prod_b;
   logic                mul_done;
   logic [HASH_W:0]     app_sum;
   logic [HASH_W-1:0]   h_new;
   logic [HASH_W:0]     qry_sum;
   logic [HASH_W-1:0]   q_hash;
   logic [LEN_W-1:0]    n_next;
   logic                mem_we;
   logic                rsp_load;

   assign req_ready = (state_ff == ST_IDLE);

   assign n_eff     = req_restart ? '0 : len_ff;
   assign base_eff  = (hash_base_ff == HASH_MOD) ? '0 : hash_base_ff;
   assign range_bad = (req_range_start > req_range_end) || (req_range_end > len_ff);

   // Entry zero of each table is never written and comes from logic.
   assign lo_hash  = (lo_ff == '0) ? '0 : rd_lo_ff;
   assign hi_hash  = (hi_ff == '0) ? '0 : rd_hi_ff;
   assign diff_pow = (diff_ff == '0) ? HASH_W'(1) : rd_pow_ff;

   assign start_a = (state_ff == ST_START);
   assign start_b = (state_ff == ST_START) && (kind_ff == KIND_APPEND);
   assign op_a1   = (kind_ff == KIND_APPEND) ? h_op_ff : lo_hash;
   assign op_a2   = (kind_ff == KIND_APPEND) ? base_ff : diff_pow;

   srh_mulmod u_mul_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .op_a    (op_a1),
      .op_b    (op_a2),
      .done    (done_a),
      .product (prod_a)
   );

   srh_mulmod u_mul_power (
      .clock   (clock),
      .reset   (reset),
      .start   (start_b),
      .op_a    (p_op_ff),
      .op_b    (base_ff),
      .done    (done_b),
      .product (prod_b)
   );

   assign mul_done = done_a && ((kind_ff == KIND_QUERY) || done_b);

   assign app_sum = {1'b0, prod_a} + (HASH_W + 1)'(byte_ff);
   assign h_new   = (app_sum >= {1'b0, HASH_MOD}) ? HASH_W'(app_sum - {1'b0, HASH_MOD})
                                                  : app_sum[HASH_W-1:0];
   assign qry_sum = {1'b0, hi_hash} + {1'b0, HASH_MOD} - {1'b0, prod_a};
   assign q_hash  = (qry_sum >= {1'b0, HASH_MOD}) ? HASH_W'(qry_sum - {1'b0, HASH_MOD})
                                                  : qry_sum[HASH_W-1:0];
   assign n_next  = n_ff + LEN_W'(1);
   assign mem_we  = (state_ff == ST_FINISH) && (kind_ff == KIND_APPEND);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prefix_mem[n_next] <= h_new;
         power_mem[n_next]  <= prod_b;
      end
      rd_lo_ff  <= prefix_mem[lo_ff];
      rd_hi_ff  <= prefix_mem[hi_ff];
      rd_pow_ff <= power_mem[diff_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_base_ff <= BASE_RESET;
         len_ff       <= '0;
         last_hash_ff <= '0;
         last_pow_ff  <= HASH_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            hash_base_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff <= req_kind;
                  byte_ff <= req_byte_value;
                  lo_ff   <= req_range_start;
                  hi_ff   <= req_range_end;
                  diff_ff <= req_range_end - req_range_start;
                  n_ff    <= n_eff;
                  h_op_ff <= req_restart ? '0 : last_hash_ff;
                  p_op_ff <= req_restart ? HASH_W'(1) : last_pow_ff;
                  base_ff <= base_eff;
                  if (req_kind == KIND_APPEND) begin
                     if (n_eff == LEN_W'(MAX_LENGTH)) begin
                        res_hash_ff   <= last_hash_ff;
                        res_status_ff <= STATUS_FULL;
                        res_len_ff    <= len_ff;
                        state_ff      <= ST_DONE;
                     end else begin
                        state_ff <= ST_START;
                     end
                  end else if (range_bad) begin
                     res_hash_ff   <= '0;
                     res_status_ff <= STATUS_BAD_RANGE;
                     res_len_ff    <= len_ff;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (mul_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               res_status_ff <= STATUS_OK;
               if (kind_ff == KIND_APPEND) begin
                  res_hash_ff  <= h_new;
                  res_len_ff   <= n_next;
                  len_ff       <= n_next;
                  last_hash_ff <= h_new;
                  last_pow_ff  <= prod_b;
               end else begin
                  res_hash_ff <= q_hash;
                  res_len_ff  <= len_ff;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_hash_ff   <= res_hash_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_len_ff    <= res_len_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hash_value    = rsp_hash_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_stored_length = rsp_len_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LENGTH))
      else $error("Stored length exceeds the table capacity.");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      done_a |-> state_ff == ST_WAIT)
      else $error("Multiplier finished outside the wait state.");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_len_ff == LEN_W'(MAX_LENGTH))
      else $error("Store-full result without a full store.");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_BAD_RANGE |-> rsp_hash_ff == '0)
      else $error("Bad-range result carries a non-zero hash.");

endmodule

// File: test/tb_substring_rolling_hash_table.sv
// ---------------------------------------------------------------------------
// Substring rolling hash table testbench
// Drives append and query transfers with random gaps on both channels. A
// scoreboard keeps its own prefix hash and base power tables modulo 2^61-1
// and predicts every result. The hash base is rewritten between phases,
// including in the middle of a string, and one string is grown until the
// store is full. Long receiver stalls push back on the request channel.
// ---------------------------------------------------------------------------
module tb_substring_rolling_hash_table;
   import srh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      logic [HASH_W-1:0]   hash;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } hash_result_type;

   class hash_table_scoreboard;
      logic [HASH_W-1:0] base;
      logic [HASH_W-1:0] prefix_model [0:MAX_LENGTH];
      logic [HASH_W-1:0] power_model [0:MAX_LENGTH];
      int unsigned       stored_length;
      hash_result_type   expected_hashes [$];
      int unsigned       mismatches;

      function new();
         base            = BASE_RESET;
         prefix_model[0] = '0;
         power_model[0]  = HASH_W'(1);
         stored_length   = 0;
         mismatches      = 0;
      endfunction

      function logic [HASH_W-1:0] fold(logic [HASH_W:0] x);
         logic [HASH_W:0] s;
         s = {1'b0, x[HASH_W-1:0]} + (HASH_W+1)'(x[HASH_W]);
         if (s >= {1'b0, HASH_MOD}) begin
            s = s - {1'b0, HASH_MOD};
         end
         return s[HASH_W-1:0];
      endfunction

      function logic [HASH_W-1:0] mul_mod(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
         logic [2*HASH_W-1:0] product;
         product = (2*HASH_W)'(a) * (2*HASH_W)'(b);
         return fold({1'b0, product[HASH_W-1:0]} + {1'b0, product[2*HASH_W-1:HASH_W]});
      endfunction

      function void set_base(logic [HASH_W-1:0] value);
         base = value;
      endfunction

      function int unsigned pending();
         return expected_hashes.size();
      endfunction

      function void note_request(logic kind, logic [BYTE_W-1:0] value, logic restart,
                                 logic [LEN_W-1:0] lo, logic [LEN_W-1:0] hi);
         hash_result_type   r;
         logic [HASH_W-1:0] b;
         logic [HASH_W-1:0] sub;
         r.hash   = '0;
         r.status = STATUS_OK;
         if (kind == KIND_APPEND) begin
            b = fold({1'b0, base});
            if (restart) begin
               stored_length = 0;
            end
            if (stored_length >= MAX_LENGTH) begin
               r.hash   = prefix_model[MAX_LENGTH];
               r.status = STATUS_FULL;
            end else begin
               power_model[stored_length+1]  = mul_mod(power_model[stored_length], b);
               prefix_model[stored_length+1] =
                  fold({1'b0, mul_mod(prefix_model[stored_length], b)} + (HASH_W+1)'(value));
               stored_length = stored_length + 1;
               r.hash        = prefix_model[stored_length];
            end
         end else if (lo > hi || hi > stored_length) begin
            r.status = STATUS_BAD_RANGE;
         end else begin
            sub    = mul_mod(prefix_model[lo], power_model[hi-lo]);
            r.hash = fold({1'b0, prefix_model[hi]} + {1'b0, HASH_MOD} - {1'b0, sub});
         end
         r.length = LEN_W'(stored_length);
         expected_hashes.push_back(r);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("%0t ns mismatch: %s", $time, msg);
      endtask

      task check_response(logic [HASH_W-1:0] hash, logic [STATUS_W-1:0] status,
                          logic [LEN_W-1:0] length);
         hash_result_type r;
         if (expected_hashes.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
         end else begin
            r = expected_hashes.pop_front();
            if (hash !== r.hash) begin
               report_mismatch($sformatf("hash %h, expected %h", hash, r.hash));
            end
            if (status !== r.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
            end
            if (length !== r.length) begin
               report_mismatch($sformatf("stored length %0d, expected %0d", length, r.length));
            end
         end
      endtask
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = KIND_APPEND;
   logic [BYTE_W-1:0]   req_byte_value = '0;
   logic                req_restart = 1'b0;
   logic [LEN_W-1:0]    req_range_start = '0;
   logic [LEN_W-1:0]    req_range_end = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [HASH_W-1:0]   rsp_hash_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [LEN_W-1:0]    rsp_stored_length;
   logic                csr_wr_en = 1'b0;
   logic [HASH_W-1:0]   csr_wr_data = '0;

   hash_table_scoreboard sb = new();
   bit                   idle_enable = 1'b1;
   int unsigned          hold_request = 0;
   int unsigned          cycles = 0;

   substring_rolling_hash_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_byte_value    (req_byte_value),
      .req_restart       (req_restart),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hash_value    (rsp_hash_value),
      .rsp_status        (rsp_status),
      .rsp_stored_length (rsp_stored_length),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task send_item(logic kind, logic [BYTE_W-1:0] value, logic restart,
                  logic [LEN_W-1:0] lo, logic [LEN_W-1:0] hi);
      int unsigned gap;
      gap = idle_enable ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_byte_value  <= value;
      req_restart     <= restart;
      req_range_start <= lo;
      req_range_end   <= hi;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, value, restart, lo, hi);
   endtask

   task release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task write_base(logic [HASH_W-1:0] value);
      release_req();
      drain();
      repeat (16) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_base(value);
   endtask

   function logic [HASH_W-1:0] random_base();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return HASH_W'(r % 64'(HASH_MOD - 3)) + HASH_W'(2);
   endfunction

   task random_item(int unsigned restart_pct, int unsigned query_pct);
      logic             kind;
      logic             restart;
      logic [LEN_W-1:0] lo;
      logic [LEN_W-1:0] hi;
      int unsigned      len;
      int unsigned      sel;
      len  = sb.stored_length;
      kind = ($urandom_range(0, 99) < query_pct) ? KIND_QUERY : KIND_APPEND;
      if (kind == KIND_QUERY) begin
         restart = 1'($urandom_range(0, 1));
      end else begin
         restart = ($urandom_range(0, 99) < restart_pct);
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         lo = LEN_W'($urandom_range(0, len));
         hi = LEN_W'($urandom_range(32'(lo), len));
      end else if (sel < 9) begin
         lo = LEN_W'($urandom_range(0, 2047));
         hi = LEN_W'($urandom_range(0, 2047));
      end else begin
         lo = LEN_W'($urandom_range(0, len));
         hi = LEN_W'($urandom_range(len + 1, 2047));
      end
      send_item(kind, BYTE_W'($urandom_range(0, 255)), restart, lo, hi);
   endtask

   task run_random(int unsigned count, int unsigned restart_pct, int unsigned query_pct);
      repeat (count) random_item(restart_pct, query_pct);
   endtask

   task grow_to(int unsigned target);
      while (sb.stored_length < target) random_item(0, 3);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset base, empty string, edge ranges and restart handling.
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd0);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd1);
      send_item(KIND_APPEND, 8'h00, 1'b0, 11'd0, 11'd0);
      send_item(KIND_APPEND, 8'hff, 1'b0, 11'd0, 11'd0);
      send_item(KIND_APPEND, 8'h80, 1'b1, 11'd0, 11'd0);
      send_item(KIND_APPEND, 8'h01, 1'b0, 11'd0, 11'd0);
      send_item(KIND_APPEND, 8'hc8, 1'b0, 11'd0, 11'd0);
      send_item(KIND_APPEND, 8'h41, 1'b0, 11'd0, 11'd0);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd4);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd1, 11'd3);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd2, 11'd2);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd3, 11'd1);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd5);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd2047, 11'd2047);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd2047);
      send_item(KIND_QUERY, 8'hff, 1'b1, 11'd0, 11'd2);
      send_item(KIND_APPEND, 8'hff, 1'b1, 11'd0, 11'd0);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd1, 11'd1);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd1);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd1024, 11'd1024);

      write_base(HASH_W'(2));
      hold_request = 400;
      run_random(20, 10, 35);

      write_base(HASH_MOD - HASH_W'(2));
      idle_enable = 1'b0;
      run_random(20, 10, 35);

      // The all-ones pattern reduces to a base of zero.
      write_base(HASH_MOD);
      idle_enable = 1'b1;
      run_random(15, 10, 35);

      write_base(random_base());
      send_item(KIND_APPEND, BYTE_W'($urandom_range(0, 255)), 1'b1, 11'd0, 11'd0);
      grow_to(500);

      // The base changes half way through the string, which then fills the store.
      write_base(random_base());
      hold_request = 600;
      grow_to(MAX_LENGTH);
      run_random(20, 0, 30);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd1024);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd1024, 11'd1024);
      send_item(KIND_APPEND, 8'h5a, 1'b1, 11'd0, 11'd0);
      send_item(KIND_QUERY, 8'h00, 1'b0, 11'd0, 11'd1);

      release_req();
      drain();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end else begin
            stall = idle_enable ? $urandom_range(0, 15) : 0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_hash_value, rsp_status, rsp_stored_length);
      end
   end

endmodule

// File: filelist.f
hw/rtl/srh_pkg.sv
hw/rtl/srh_mulmod.sv
hw/rtl/substring_rolling_hash_table.sv
test/tb_substring_rolling_hash_table.sv
